>>> hw/rtl/t2s_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package t2s_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int NCH        = 4;
    localparam int VAL_W      = 16;
    localparam int COORD_W    = 20;
    localparam int FRAC       = 16;
    localparam int SIDE_W     = 7;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = 3'd5;

    // One axis of a sample: first and second texel index, fraction, outside flag
    typedef struct packed {
        logic signed [12:0] lo;
        logic signed [12:0] hi;
        logic [FRAC-1:0]    frac;
        logic               out;
    } t_axis;

endpackage
`default_nettype wire

>>> hw/rtl/t2s_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module t2s_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hw/rtl/texture_2d_sampler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Texture store of MAX_WIDTH x MAX_HEIGHT texels, four Q8.8 channels each.
// Input items (s_axis): tuser carries the opcode (write, read, sample, clear),
// tdata the coordinates, texel position and four channel values.
// Result items (m_axis): tdata four channels, tuser the outside flag.
// Configuration: write i_cfg_wdata to register i_cfg_index while i_cfg_we.
// One item at a time; tready is high only while the sequencer is idle.
// A clear sweeps the store one texel per cycle through the single
// write port. Samples go through one shared multiplier; corners of a
// bilinear sample that lie outside the texture are skipped, and in
// gradient mode each inside corner is written back to the store.
// Reset: the configuration registers take their defaults and the store
// is swept to zero; no item is accepted during the sweep.
// A stalled receiver holds the output register; the block may take the
// next item meanwhile but waits to deliver its result until it is taken.
module texture_2d_sampler_unit #(
    parameter int MAX_WIDTH  = t2s_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = t2s_pkg::MAX_HEIGHT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // s_axis tuser: opcode[1:0]
    // s_axis tdata: coord_u[19:0] coord_v[39:20] texel_col[45:40]
    //   texel_row[51:46] value_ch0[67:52] value_ch1[83:68]
    //   value_ch2[99:84] value_ch3[115:100], zero fill to 120
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [t2s_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    input  wire logic [1:0]                         i_s_axis_tuser,
    // m_axis tdata: result_ch0[15:0] result_ch1[31:16] result_ch2[47:32]
    //   result_ch3[63:48]
    // m_axis tuser: outside_flag[0]
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic [t2s_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    output logic [0:0]                              o_m_axis_tuser,
    input  wire logic                               i_cfg_we,
    input  wire logic [t2s_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [t2s_pkg::CFG_W-1:0]          i_cfg_wdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW    = t2s_pkg::VAL_W;
    localparam int FR    = t2s_pkg::FRAC;
    localparam int SW    = t2s_pkg::SIDE_W;
    localparam int PW    = 52;
    localparam int WW    = 2 * FR + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_TXRD, S_MULU, S_MULV, S_SPLIT, S_SETUP,
        S_CORNER, S_WGT, S_CH, S_ACC, S_WB, S_DONE, S_OUT
    } t_state;

    t_state r_state;

    // Configuration
    logic          r_bil, r_clampb, r_grad;
    logic [SW-1:0] r_tw, r_th;
    logic [2:0]    r_nch_raw;
    logic [SW-1:0] w_eff, h_eff;
    logic [2:0]    nch;

    // Item registers
    t2s_pkg::t_op                    r_op;
    logic signed [t2s_pkg::COORD_W-1:0] r_u, r_v;
    logic signed [VW-1:0]            r_g   [t2s_pkg::NCH];
    logic signed [VW-1:0]            r_tex [t2s_pkg::NCH];
    logic signed [PW-1:0]            r_acc [t2s_pkg::NCH];
    logic [AW-1:0]                   r_addr;
    logic                            r_addr_ok;
    logic signed [27:0]              r_u_sc, r_v_sc;
    t2s_pkg::t_axis                  r_ax, r_ay;
    t2s_pkg::t_axis                  ax, ay;
    logic [1:0]                      r_k, r_c;
    logic [WW-1:0]                   r_w;
    logic [AW-1:0]                   r_clr;
    logic signed [VW-1:0]            r_res [t2s_pkg::NCH];
    logic                            r_res_flag;

    // Shared multiplier
    logic signed [33:0]   mul_a;
    logic signed [17:0]   mul_b;
    logic signed [PW-1:0] r_prod;

    // Store port
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr, ram_raddr;
    logic [t2s_pkg::OUT_DATA_W-1:0]  ram_wdata, ram_rdata;

    // Corner under work
    logic signed [12:0] cx, cy;
    logic               corner_ok;
    logic [AW-1:0]      corner_addr;
    logic [FR:0]        wxs, wys;
    logic               last_corner;
    logic signed [VW-1:0] rd_ch [t2s_pkg::NCH];
    logic signed [19:0] d_grad;
    logic signed [19:0] acc_rnd [t2s_pkg::NCH];
    logic               in_acc;
    logic [AW-1:0]      in_addr;
    logic               in_ok;
    logic [5:0]         in_col, in_row;

    function automatic logic signed [VW-1:0] sat16(input logic signed [20:0] x);
        if (x > 21'sd32767) begin
            return 16'sh7fff;
        end else if (x < -21'sd32768) begin
            return 16'sh8000;
        end
        return x[VW-1:0];
    endfunction

    function automatic t2s_pkg::t_axis axis_split(input logic signed [27:0] s,
                                                  input logic [SW-1:0] n,
                                                  input logic bil,
                                                  input logic clampb);
        logic signed [28:0] a;
        logic signed [28:0] top;
        logic signed [12:0] i;
        logic signed [13:0] ns;
        t2s_pkg::t_axis r;
        ns = $signed({7'd0, n});
        r  = '0;
        a  = '0;
        top = $signed({6'd0, n - 7'd1, 16'd0});
        i  = 13'(s >>> FR);
        if (!bil) begin
            r.out = (i < 13'sd0) || ($signed({i[12], i}) >= ns);
            if (clampb) begin
                if (i < 13'sd0) begin
                    i = '0;
                end else if ($signed({i[12], i}) >= ns) begin
                    i = 13'(ns - 14'sd1);
                end
            end
            r.lo = i;
            r.hi = i;
        end else begin
            a = $signed({s[27], s}) - 29'sd32768;
            if (clampb) begin
                if (a < 29'sd0) begin
                    a = '0;
                end else if (a > top) begin
                    a = top;
                end
            end
            r.lo   = 13'(a >>> FR);
            r.frac = a[FR-1:0];
            r.hi   = r.lo + $signed({12'd0, |a[FR-1:0]});
        end
        return r;
    endfunction

    // Effective register values
    always_comb begin
        if (r_tw == '0) begin
            w_eff = 7'd1;
        end else if (int'(r_tw) > MAX_WIDTH) begin
            w_eff = SW'(MAX_WIDTH);
        end else begin
            w_eff = r_tw;
        end
        if (r_th == '0) begin
            h_eff = 7'd1;
        end else if (int'(r_th) > MAX_HEIGHT) begin
            h_eff = SW'(MAX_HEIGHT);
        end else begin
            h_eff = r_th;
        end
        if (r_nch_raw == 3'd0) begin
            nch = 3'd1;
        end else if (r_nch_raw > 3'd4) begin
            nch = 3'd4;
        end else begin
            nch = r_nch_raw;
        end
    end

    assign ax = axis_split(r_u_sc, w_eff, r_bil, r_clampb);
    assign ay = axis_split(r_v_sc, h_eff, r_bil, r_clampb);

    // Input texel address
    assign in_col  = i_s_axis_tdata[45:40];
    assign in_row  = i_s_axis_tdata[51:46];
    assign in_ok   = (int'(in_col) < MAX_WIDTH) && (int'(in_row) < MAX_HEIGHT);
    assign in_addr = AW'(int'(in_row) * MAX_WIDTH + int'(in_col));
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;

    // Corner selection and bounds
    always_comb begin
        cx = r_k[0] ? r_ax.hi : r_ax.lo;
        cy = r_k[1] ? r_ay.hi : r_ay.lo;
        corner_ok = (cx >= 13'sd0) && ($signed({cx[12], cx}) < $signed({7'd0, w_eff}))
                 && (cy >= 13'sd0) && ($signed({cy[12], cy}) < $signed({7'd0, h_eff}));
        corner_addr = AW'(int'(cy) * MAX_WIDTH + int'(cx));
        wxs = r_k[0] ? {1'b0, r_ax.frac} : (17'h10000 - {1'b0, r_ax.frac});
        wys = r_k[1] ? {1'b0, r_ay.frac} : (17'h10000 - {1'b0, r_ay.frac});
        last_corner = !r_bil || (r_k == 2'd3);
    end

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MULU: begin
                mul_a = 34'(r_u);
                mul_b = $signed({11'd0, w_eff});
            end
            S_MULV: begin
                mul_a = 34'(r_v);
                mul_b = $signed({11'd0, h_eff});
            end
            S_CORNER: begin
                mul_a = $signed({17'd0, wxs});
                mul_b = $signed({1'b0, wys});
            end
            S_CH: begin
                mul_a = $signed({1'b0, r_w});
                mul_b = r_grad ? 18'(r_g[r_c]) : 18'(r_tex[r_c]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounding of the product and of the accumulators
    always_comb begin
        d_grad = 20'((r_prod + (52'sd1 <<< (2 * FR - 1))) >>> (2 * FR));
        for (int c = 0; c < t2s_pkg::NCH; c++) begin
            rd_ch[c]   = ram_rdata[c*VW +: VW];
            acc_rnd[c] = 20'((r_acc[c] + (52'sd1 <<< (2 * FR - 1))) >>> (2 * FR));
        end
    end

    // Store port select
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        ram_raddr = (r_state == S_IDLE) ? in_addr : corner_addr;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            S_TXRD: begin
                ram_we = (r_op == t2s_pkg::OP_WRITE) && r_addr_ok;
                for (int c = 0; c < t2s_pkg::NCH; c++) begin
                    ram_wdata[c*VW +: VW] = (3'(c) < nch) ? r_g[c] : rd_ch[c];
                end
            end
            S_WB: begin
                ram_we = 1'b1;
                for (int c = 0; c < t2s_pkg::NCH; c++) begin
                    ram_wdata[c*VW +: VW] = r_tex[c];
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    t2s_ram #(
        .WIDTH (t2s_pkg::OUT_DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr           <= '0;
            r_bil           <= 1'b1;
            r_clampb        <= 1'b0;
            r_grad          <= 1'b0;
            r_tw            <= 7'd64;
            r_th            <= 7'd64;
            r_nch_raw       <= 3'd4;
            o_m_axis_tvalid <= 1'b0;
        end else begin
            // Take configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    t2s_pkg::CFG_SAMPLE_MODE: r_bil     <= i_cfg_wdata[0];
                    t2s_pkg::CFG_BORDER_MODE: r_clampb  <= i_cfg_wdata[0];
                    t2s_pkg::CFG_GRAD_MODE:   r_grad    <= i_cfg_wdata[0];
                    t2s_pkg::CFG_TEX_WIDTH:   r_tw      <= i_cfg_wdata;
                    t2s_pkg::CFG_TEX_HEIGHT:  r_th      <= i_cfg_wdata;
                    t2s_pkg::CFG_CHANNELS:    r_nch_raw <= i_cfg_wdata[2:0];
                    default: ;
                endcase
            end
            // Drop a delivered result unless the output stage refills it
            if (o_m_axis_tvalid && i_m_axis_tready && (r_state != S_OUT)) begin
                o_m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (int'(r_clr) == DEPTH - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_op      <= t2s_pkg::t_op'(i_s_axis_tuser);
                        r_u       <= i_s_axis_tdata[19:0];
                        r_v       <= i_s_axis_tdata[39:20];
                        r_addr    <= in_addr;
                        r_addr_ok <= in_ok;
                        for (int c = 0; c < t2s_pkg::NCH; c++) begin
                            r_g[c] <= i_s_axis_tdata[52 + c*VW +: VW];
                        end
                        unique case (t2s_pkg::t_op'(i_s_axis_tuser))
                            t2s_pkg::OP_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= S_CLEAR;
                            end
                            t2s_pkg::OP_SAMPLE: r_state <= S_MULU;
                            default:            r_state <= S_TXRD;
                        endcase
                    end
                end
                S_TXRD: begin
                    if (r_op == t2s_pkg::OP_WRITE) begin
                        r_state <= S_IDLE;
                    end else begin
                        for (int c = 0; c < t2s_pkg::NCH; c++) begin
                            r_res[c] <= (r_addr_ok && (3'(c) < nch)) ? rd_ch[c] : '0;
                        end
                        r_res_flag <= 1'b0;
                        r_state    <= S_OUT;
                    end
                end
                S_MULU: r_state <= S_MULV;
                S_MULV: begin
                    r_u_sc  <= r_prod[27:0];
                    r_state <= S_SPLIT;
                end
                S_SPLIT: begin
                    r_v_sc  <= r_prod[27:0];
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    r_ax <= ax;
                    r_ay <= ay;
                    r_k  <= '0;
                    for (int c = 0; c < t2s_pkg::NCH; c++) begin
                        r_acc[c] <= '0;
                        r_res[c] <= '0;
                    end
                    if (!r_bil && (ax.out || ay.out) && !r_clampb) begin
                        r_res_flag <= 1'b1;
                        r_state    <= r_grad ? S_IDLE : S_OUT;
                    end else begin
                        r_state <= S_CORNER;
                    end
                end
                S_CORNER: begin
                    r_addr <= corner_addr;
                    if (corner_ok) begin
                        r_state <= S_WGT;
                    end else if (last_corner) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_WGT: begin
                    r_w <= r_bil ? r_prod[WW-1:0] : (WW'(1) << (2 * FR));
                    for (int c = 0; c < t2s_pkg::NCH; c++) begin
                        r_tex[c] <= rd_ch[c];
                    end
                    r_c     <= '0;
                    r_state <= S_CH;
                end
                S_CH: r_state <= S_ACC;
                S_ACC: begin
                    if (r_grad) begin
                        if ({1'b0, r_c} < nch) begin
                            r_tex[r_c] <= sat16(21'(r_tex[r_c]) + 21'(d_grad));
                        end
                    end else begin
                        r_acc[r_c] <= r_acc[r_c] + r_prod;
                    end
                    if (r_c != 2'd3) begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_CH;
                    end else if (r_grad) begin
                        r_state <= S_WB;
                    end else if (last_corner) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_CORNER;
                    end
                end
                S_WB: begin
                    if (last_corner) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_CORNER;
                    end
                end
                S_DONE: begin
                    for (int c = 0; c < t2s_pkg::NCH; c++) begin
                        r_res[c] <= (3'(c) < nch) ? sat16(21'(acc_rnd[c])) : '0;
                    end
                    r_res_flag <= 1'b0;
                    r_state    <= r_grad ? S_IDLE : S_OUT;
                end
                S_OUT: begin
                    if (!o_m_axis_tvalid || i_m_axis_tready) begin
                        for (int c = 0; c < t2s_pkg::NCH; c++) begin
                            o_m_axis_tdata[c*VW +: VW] <= r_res[c];
                        end
                        o_m_axis_tuser[0] <= r_res_flag;
                        o_m_axis_tvalid   <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    // One item in flight: the sequencer leaves idle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_axis_tready)
        else $error("item accepted while sequencer busy");

    // A new result only comes from the output stage
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output stage");

    // Outside nearest samples carry zero data
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("outside flag with nonzero data");

    // The store is never written while idle
    a_idle_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("store written while idle");

endmodule
`default_nettype wire
